@@ sv/ils_pkg.sv @@
package ils_pkg;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_WRITE  = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_DEL_EQ = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  position;
        logic [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [6:0]  length;
        logic [6:0]  removed_count;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_FINISH
    } state_t;

endpackage

@@ sv/indexed_list_store.sv @@
// Ordered list of up to CAPACITY words held in a simple dual-port memory with one
// write and one registered read per cycle. A transaction is taken when start is high
// and busy is low; its result appears on result with done high for exactly one cycle
// and cannot be held off. No new transaction is taken while busy is high. Entries
// move one at a time, each read and then written back: insert moves length-position
// entries, delete moves length-position-1, delete-all-equal scans all length entries
// and a read fetches one. There is no clearing pass.
module indexed_list_store #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ils_pkg::cmd_t command,
    output logic          busy,
    output logic          done,
    output ils_pkg::rsp_t result
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 7;

    ils_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [2:0]            op_reg, op_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [1:0]            status_reg, status_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [AW-1:0]         end_reg, end_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         src_reg, src_next;
    logic [CNT_W-1:0]      wptr_reg, wptr_next;
    logic [CNT_W-1:0]      removed_reg, removed_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    logic                  done_reg, done_next;
    ils_pkg::rsp_t         rsp_reg, rsp_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [AW-1:0]    last_addr;

    ils_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ils_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    assign pos_c     = CMP_W'(command.position);
    assign cnt_c     = CMP_W'(count_reg);
    assign last_addr = AW'(count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ils_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        ptr_reg     <= ptr_next;
        end_reg     <= end_next;
        src_reg     <= src_next;
        wptr_reg    <= wptr_next;
        removed_reg <= removed_next;
        rd_reg      <= rd_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        pend_next    = 1'b0;
        src_next     = src_reg;
        wptr_next    = wptr_reg;
        removed_next = removed_reg;
        rd_next      = rd_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        ram_we       = 1'b0;
        ram_waddr    = src_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = ptr_reg;

        // The word fetched in the previous cycle is handled here: moved one slot
        // or kept by the compaction, or captured for a read.
        if (pend_reg)
        begin
            case (op_reg)
                ils_pkg::CMD_INSERT:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = src_reg + AW'(1);
                end
                ils_pkg::CMD_DELETE:
                begin
                    ram_we    = 1'b1;
                    ram_waddr = src_reg - AW'(1);
                end
                ils_pkg::CMD_READ:
                begin
                    rd_next = ram_rdata;
                end
                ils_pkg::CMD_DEL_EQ:
                begin
                    if (ram_rdata == val_reg)
                    begin
                        removed_next = removed_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wptr_reg[AW-1:0];
                        wptr_next = wptr_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ils_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next      = command.cmd;
                    pos_next     = AW'(command.position);
                    val_next     = DATA_WIDTH'(command.value);
                    status_next  = ils_pkg::STATUS_OK;
                    wptr_next    = '0;
                    removed_next = '0;
                    rd_next      = '0;
                    state_next   = ils_pkg::S_FINISH;
                    case (command.cmd)
                        ils_pkg::CMD_INSERT:
                        begin
                            if (pos_c > cnt_c)
                            begin
                                status_next = ils_pkg::STATUS_RANGE;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ils_pkg::STATUS_FULL;
                            end
                            else if (pos_c < cnt_c)
                            begin
                                ptr_next   = last_addr;
                                end_next   = AW'(command.position);
                                state_next = ils_pkg::S_SCAN;
                            end
                        end
                        ils_pkg::CMD_DELETE:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                status_next = ils_pkg::STATUS_RANGE;
                            end
                            else if (pos_c + CMP_W'(1) < cnt_c)
                            begin
                                ptr_next   = AW'(command.position) + AW'(1);
                                end_next   = last_addr;
                                state_next = ils_pkg::S_SCAN;
                            end
                        end
                        ils_pkg::CMD_WRITE:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                status_next = ils_pkg::STATUS_RANGE;
                            end
                        end
                        ils_pkg::CMD_READ:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                status_next = ils_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                ptr_next   = AW'(command.position);
                                end_next   = AW'(command.position);
                                state_next = ils_pkg::S_SCAN;
                            end
                        end
                        ils_pkg::CMD_DEL_EQ:
                        begin
                            if (count_reg != '0)
                            begin
                                ptr_next   = '0;
                                end_next   = last_addr;
                                state_next = ils_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ils_pkg::S_SCAN:
            begin
                ram_raddr = ptr_reg;
                pend_next = 1'b1;
                src_next  = ptr_reg;
                if (ptr_reg == end_reg)
                begin
                    state_next = ils_pkg::S_FLUSH;
                end
                else if (op_reg == ils_pkg::CMD_INSERT)
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ils_pkg::S_FLUSH:
            begin
                state_next = ils_pkg::S_FINISH;
            end
            ils_pkg::S_FINISH:
            begin
                if (status_reg == ils_pkg::STATUS_OK)
                begin
                    case (op_reg)
                        ils_pkg::CMD_INSERT:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = pos_reg;
                            ram_wdata  = val_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                        ils_pkg::CMD_DELETE:
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        ils_pkg::CMD_WRITE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_reg;
                            ram_wdata = val_reg;
                        end
                        ils_pkg::CMD_DEL_EQ:
                        begin
                            count_next = count_reg - removed_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                rsp_next.status        = status_reg;
                rsp_next.read_value    = 32'(rd_reg);
                rsp_next.length        = 7'(count_next);
                rsp_next.removed_count = 7'(removed_reg);
                done_next              = 1'b1;
                state_next             = ils_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ils_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ils_ram.sv @@
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
